// File: rtl/udp_port_flow_demux_table_core_assert.svh
// Assertion helpers for the UDP demux core; clk and arst_n come from the using module.
`ifndef UDP_PORT_FLOW_DEMUX_TABLE_CORE_ASSERT_SVH
`define UDP_PORT_FLOW_DEMUX_TABLE_CORE_ASSERT_SVH

// condition must hold on every clock outside reset
`define UDPFD_ASSERT(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// consequence must hold on the clock after the trigger
`define UDPFD_ASSERT_NEXT(lbl, trig, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/udpfd_pkg.sv
`timescale 1ns / 1ps
package udpfd_pkg;

	localparam logic [15:0] PORT_BASE_RESET = 16'd50000;
	localparam logic [15:0] UDP_HDR_BYTES   = 16'd8;

	typedef enum logic [2:0] {
		CMD_DGRAM  = 3'd0,
		CMD_SRV    = 3'd1,
		CMD_CLI    = 3'd2,
		CMD_SEND   = 3'd3,
		CMD_LATEST = 3'd4
	} cmd_e_t;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_NEW     = 3'd1,
		ST_NOPORT  = 3'd2,
		ST_UNKPEER = 3'd3,
		ST_FULL    = 3'd4,
		ST_INUSE   = 3'd5,
		ST_UNKSOCK = 3'd6,
		ST_EMPTY   = 3'd7
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE, S_FIND, S_ACT, S_SCAN, S_LAT, S_MISS, S_EMIT
	} state_t;

	typedef enum logic [2:0] {
		O_NOPORT, O_FULL, O_INUSE, O_OPEN, O_SLOT, O_EMPTY
	} outcome_t;

	localparam logic [0:0] CFG_LOCAL_IP  = 1'd0;
	localparam logic [0:0] CFG_PORT_BASE = 1'd1;

	typedef struct packed {
		cmd_e_t      cmd;
		logic [31:0] peer_address;
		logic [15:0] src_port;
		logic [15:0] port_value;
		logic [2:0]  slot_select;
		logic [15:0] socket_select;
		logic [15:0] payload_length;
	} item_t;

	typedef struct packed {
		logic  valid;
		item_t item;
	} qif_t;

	typedef struct packed {
		status_t     status;
		logic [2:0]  slot_out;
		logic        is_server;
		logic [15:0] socket_out;
		logic [31:0] remote_address_out;
		logic [15:0] remote_port_out;
		logic [15:0] local_port_out;
		logic [31:0] source_address_out;
		logic [15:0] udp_length_out;
	} result_t;

	typedef struct packed {
		logic [31:0] addr;
		logic [15:0] port;
		logic [15:0] sock;
	} flow_t;

endpackage

// File: rtl/udp_port_flow_demux_table_core.sv
// Sequence: an accepted item passes S_FIND and S_ACT; a lookup reads its slot's flow
// entries in S_SCAN (a latest query reads one in S_LAT) and passes S_MISS if a datagram
// or send lookup misses every flow of its slot; S_EMIT then fills the output register.
// Throughput: one item in execution at a time; a two-entry queue keeps accepting until full.
// Reset (async, active low) closes all slots, zeroes the ephemeral offset and restores
// the configuration defaults; the flow memory is not cleared and needs no clearing pass.
`timescale 1ns / 1ps
module udp_port_flow_demux_table_core #(
	parameter int LOCAL_ENTRIES   = 8,
	parameter int FLOWS_PER_LOCAL = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// config write port
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [31:0] cfg_data,
	// item input
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  cmd,
	input  logic [31:0] peer_address,
	input  logic [15:0] src_port,
	input  logic [15:0] port_value,
	input  logic [2:0]  slot_select,
	input  logic [15:0] socket_select,
	input  logic [15:0] payload_length,
	// result output
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [2:0]  slot_out,
	output logic        is_server,
	output logic [15:0] socket_out,
	output logic [31:0] remote_address_out,
	output logic [15:0] remote_port_out,
	output logic [15:0] local_port_out,
	output logic [31:0] source_address_out,
	output logic [15:0] udp_length_out
);
	import udpfd_pkg::*;

	qif_t    q;
	logic    q_pop;
	result_t res;

	// front: decodes cmd, drops unknown codes, queues the item
	udpfd_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.cmd            (cmd),
		.peer_address   (peer_address),
		.src_port       (src_port),
		.port_value     (port_value),
		.slot_select    (slot_select),
		.socket_select  (socket_select),
		.payload_length (payload_length),
		.q              (q),
		.q_pop          (q_pop)
	);

	// back: slot match, flow scan/learn, header build, output register
	udpfd_engine #(
		.LOCAL_ENTRIES   (LOCAL_ENTRIES),
		.FLOWS_PER_LOCAL (FLOWS_PER_LOCAL)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.q         (q),
		.q_pop     (q_pop),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.res       (res),
		.out_valid (out_valid),
		.out_stall (out_stall)
	);

	assign status             = res.status;
	assign slot_out           = res.slot_out;
	assign is_server          = res.is_server;
	assign socket_out         = res.socket_out;
	assign remote_address_out = res.remote_address_out;
	assign remote_port_out    = res.remote_port_out;
	assign local_port_out     = res.local_port_out;
	assign source_address_out = res.source_address_out;
	assign udp_length_out     = res.udp_length_out;

endmodule

// File: rtl/udpfd_front.sv
`timescale 1ns / 1ps
module udpfd_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         cmd,
	input  logic [31:0]        peer_address,
	input  logic [15:0]        src_port,
	input  logic [15:0]        port_value,
	input  logic [2:0]         slot_select,
	input  logic [15:0]        socket_select,
	input  logic [15:0]        payload_length,
	output udpfd_pkg::qif_t    q,
	input  logic               q_pop
);
	import udpfd_pkg::*;

	item_t      ent_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       cmd_ok;
	cmd_e_t     cmd_dec;
	logic       push;

	// unknown codes are taken and dropped
	always_comb begin
		cmd_ok  = 1'b1;
		cmd_dec = CMD_DGRAM;
		unique case (cmd)
			3'd0: cmd_dec = CMD_DGRAM;
			3'd1: cmd_dec = CMD_SRV;
			3'd2: cmd_dec = CMD_CLI;
			3'd3: cmd_dec = CMD_SEND;
			3'd4: cmd_dec = CMD_LATEST;
			default: cmd_ok = 1'b0;
		endcase
	end

	assign in_stall = (cnt_q == 2'd2);
	assign push     = in_valid && !in_stall && cmd_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wp_q <= ~wp_q;
			if (q_pop)
				rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			ent_q[wp_q] <= '{cmd: cmd_dec, peer_address: peer_address,
				src_port: src_port, port_value: port_value,
				slot_select: slot_select, socket_select: socket_select,
				payload_length: payload_length};
	end

	assign q.valid = (cnt_q != 2'd0);
	assign q.item  = ent_q[rp_q];

endmodule

// File: rtl/udpfd_engine.sv
`timescale 1ns / 1ps
`include "udp_port_flow_demux_table_core_assert.svh"
module udpfd_engine #(
	parameter int LOCAL_ENTRIES   = 8,
	parameter int FLOWS_PER_LOCAL = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  udpfd_pkg::qif_t    q,
	output logic               q_pop,
	input  logic               cfg_we,
	input  logic [0:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	output udpfd_pkg::result_t res,
	output logic               out_valid,
	input  logic               out_stall
);
	import udpfd_pkg::*;

	localparam int SW    = (LOCAL_ENTRIES > 1) ? $clog2(LOCAL_ENTRIES) : 1;
	localparam int FIW   = (FLOWS_PER_LOCAL > 1) ? $clog2(FLOWS_PER_LOCAL) : 1;
	localparam int CW    = $clog2(FLOWS_PER_LOCAL + 1);
	localparam int DEPTH = LOCAL_ENTRIES * FLOWS_PER_LOCAL;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	// local slot table
	logic            lv_q     [LOCAL_ENTRIES];
	logic [15:0]     lport_q  [LOCAL_ENTRIES];
	logic            lsrv_q   [LOCAL_ENTRIES];
	logic [15:0]     nsid_q   [LOCAL_ENTRIES];
	logic            latv_q   [LOCAL_ENTRIES];
	logic [FIW-1:0]  latidx_q [LOCAL_ENTRIES];

	flow_t           mem [DEPTH];
	flow_t           rd_q;

	logic [31:0]     ip_q;
	logic [15:0]     base_q, off_q, cli_port_q;
	state_t          state_q, state_d;
	item_t           it_q;
	logic [SW-1:0]   slot_q;
	outcome_t        outc_q;
	logic [CW-1:0]   j_q;
	result_t         res_q, out_q;
	logic            ovalid_q;

	// comb control
	logic [15:0]     key;
	logic            phit, fhit;
	logic [SW-1:0]   pidx, fidx;
	outcome_t        fnd_outc;
	logic [SW-1:0]   fnd_slot;
	logic [CW-1:0]   n_cur;
	logic            srv_cur;
	logic [15:0]     port_cur;
	logic [AW-1:0]   base_addr;
	logic            rd_en, mem_we, open_en, add_en, res_ld, emit_go, j_ld, off_inc;
	logic [FIW-1:0]  rd_j, wr_j;
	logic [CW-1:0]   j_d;
	flow_t           mem_wd;
	result_t         res_d;
	logic            hit;

	assign key = (it_q.cmd == CMD_CLI) ? base_q + off_q : it_q.port_value;

	// lowest matching / free slot
	always_comb begin
		phit = 1'b0;
		fhit = 1'b0;
		pidx = '0;
		fidx = '0;
		for (int i = LOCAL_ENTRIES - 1; i >= 0; i--) begin
			if (lv_q[i] && lport_q[i] == key) begin
				phit = 1'b1;
				pidx = SW'(i);
			end
			if (!lv_q[i]) begin
				fhit = 1'b1;
				fidx = SW'(i);
			end
		end
	end

	always_comb begin
		fnd_outc = O_EMPTY;
		fnd_slot = '0;
		off_inc  = 1'b0;
		unique case (it_q.cmd)
			CMD_DGRAM: begin
				fnd_outc = phit ? O_SLOT : O_NOPORT;
				fnd_slot = pidx;
			end
			CMD_SRV: begin
				fnd_outc = phit ? O_INUSE : (fhit ? O_OPEN : O_FULL);
				fnd_slot = phit ? pidx : fidx;
			end
			CMD_CLI: begin
				off_inc  = fhit;
				fnd_outc = !fhit ? O_FULL : (phit ? O_INUSE : O_OPEN);
				fnd_slot = phit ? pidx : fidx;
			end
			CMD_SEND, CMD_LATEST: begin
				fnd_slot = SW'(it_q.slot_select);
				if (int'(it_q.slot_select) >= LOCAL_ENTRIES || !lv_q[fnd_slot])
					fnd_outc = O_EMPTY;
				else
					fnd_outc = O_SLOT;
			end
			default: fnd_outc = O_EMPTY;
		endcase
	end

	assign n_cur     = latv_q[slot_q] ? CW'(latidx_q[slot_q]) + CW'(1) : '0;
	assign srv_cur   = lsrv_q[slot_q];
	assign port_cur  = lport_q[slot_q];
	assign base_addr = AW'(slot_q) * AW'(FLOWS_PER_LOCAL);
	assign hit = (it_q.cmd == CMD_DGRAM) ?
		(rd_q.addr == it_q.peer_address && rd_q.port == it_q.src_port) :
		(rd_q.sock == it_q.socket_select);

	always_comb begin
		state_d = state_q;
		q_pop   = 1'b0;
		rd_en   = 1'b0;
		rd_j    = '0;
		mem_we  = 1'b0;
		wr_j    = '0;
		mem_wd  = '0;
		open_en = 1'b0;
		add_en  = 1'b0;
		res_ld  = 1'b0;
		res_d   = '0;
		emit_go = 1'b0;
		j_ld    = 1'b0;
		j_d     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (q.valid) begin
					q_pop   = 1'b1;
					state_d = S_FIND;
				end
			end
			S_FIND: state_d = S_ACT;
			S_ACT: begin
				state_d = S_EMIT;
				res_ld  = 1'b1;
				case (outc_q)
					O_NOPORT: res_d.status = ST_NOPORT;
					O_FULL:   res_d.status = ST_FULL;
					O_EMPTY: begin
						res_d.status   = ST_EMPTY;
						res_d.slot_out = it_q.slot_select;
					end
					O_INUSE: begin
						res_d.status         = ST_INUSE;
						res_d.slot_out       = 3'(slot_q);
						res_d.is_server      = srv_cur;
						res_d.local_port_out = (it_q.cmd == CMD_SRV) ?
							it_q.port_value : cli_port_q;
					end
					O_OPEN: begin
						open_en              = 1'b1;
						res_d.status         = ST_OK;
						res_d.slot_out       = 3'(slot_q);
						if (it_q.cmd == CMD_SRV) begin
							res_d.is_server      = 1'b1;
							res_d.local_port_out = it_q.port_value;
						end else begin
							// the peer becomes socket 0 of the new client slot
							mem_we                   = 1'b1;
							mem_wd                   = '{addr: it_q.peer_address,
								port: it_q.port_value, sock: 16'd0};
							res_d.remote_address_out = it_q.peer_address;
							res_d.remote_port_out    = it_q.port_value;
							res_d.local_port_out     = cli_port_q;
						end
					end
					default: begin
						res_d.slot_out       = 3'(slot_q);
						res_d.is_server      = srv_cur;
						res_d.local_port_out = port_cur;
						if (it_q.cmd == CMD_LATEST) begin
							if (n_cur == '0) begin
								res_d.status = ST_EMPTY;
							end else begin
								res_ld  = 1'b0;
								rd_en   = 1'b1;
								rd_j    = latidx_q[slot_q];
								state_d = S_LAT;
							end
						end else begin
							res_ld = 1'b0;
							if (n_cur == '0) begin
								state_d = S_MISS;
							end else begin
								rd_en   = 1'b1;
								j_ld    = 1'b1;
								state_d = S_SCAN;
							end
						end
					end
				endcase
			end
			S_SCAN: begin
				if (hit) begin
					res_ld                   = 1'b1;
					res_d.status             = ST_OK;
					res_d.slot_out           = 3'(slot_q);
					res_d.is_server          = srv_cur;
					res_d.socket_out         = rd_q.sock;
					res_d.remote_address_out = rd_q.addr;
					res_d.remote_port_out    = rd_q.port;
					res_d.local_port_out     = port_cur;
					if (it_q.cmd == CMD_SEND) begin
						res_d.source_address_out = ip_q;
						res_d.udp_length_out     = it_q.payload_length + UDP_HDR_BYTES;
					end
					state_d = S_EMIT;
				end else if (j_q + CW'(1) < n_cur) begin
					rd_en = 1'b1;
					rd_j  = FIW'(j_q + CW'(1));
					j_ld  = 1'b1;
					j_d   = j_q + CW'(1);
				end else begin
					state_d = S_MISS;
				end
			end
			S_LAT: begin
				res_ld                   = 1'b1;
				res_d.status             = ST_OK;
				res_d.slot_out           = 3'(slot_q);
				res_d.is_server          = srv_cur;
				res_d.socket_out         = rd_q.sock;
				res_d.remote_address_out = rd_q.addr;
				res_d.remote_port_out    = rd_q.port;
				res_d.local_port_out     = port_cur;
				state_d                  = S_EMIT;
			end
			S_MISS: begin
				res_ld               = 1'b1;
				state_d              = S_EMIT;
				res_d.slot_out       = 3'(slot_q);
				res_d.is_server      = srv_cur;
				res_d.local_port_out = port_cur;
				if (it_q.cmd == CMD_SEND) begin
					res_d.status = ST_UNKSOCK;
				end else begin
					res_d.remote_address_out = it_q.peer_address;
					res_d.remote_port_out    = it_q.src_port;
					if (!srv_cur) begin
						res_d.status = ST_UNKPEER;
					end else if (n_cur >= CW'(FLOWS_PER_LOCAL)) begin
						res_d.status = ST_FULL;
					end else begin
						// learn the new peer at the end of the slot's list
						add_en           = 1'b1;
						mem_we           = 1'b1;
						wr_j             = FIW'(n_cur);
						mem_wd           = '{addr: it_q.peer_address,
							port: it_q.src_port, sock: nsid_q[slot_q]};
						res_d.status     = ST_NEW;
						res_d.socket_out = nsid_q[slot_q];
					end
				end
			end
			S_EMIT: begin
				if (!ovalid_q || !out_stall) begin
					emit_go = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ip_q     <= '0;
			base_q   <= PORT_BASE_RESET;
			off_q    <= '0;
			ovalid_q <= 1'b0;
			for (int i = 0; i < LOCAL_ENTRIES; i++) begin
				lv_q[i]   <= 1'b0;
				latv_q[i] <= 1'b0;
			end
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_LOCAL_IP:  ip_q   <= cfg_data;
					CFG_PORT_BASE: base_q <= cfg_data[15:0];
					default: ;
				endcase
			end
			if (state_q == S_FIND && off_inc)
				off_q <= off_q + 16'd1;
			if (open_en) begin
				lv_q[slot_q]   <= 1'b1;
				latv_q[slot_q] <= (it_q.cmd == CMD_CLI);
			end
			if (add_en)
				latv_q[slot_q] <= 1'b1;
			if (emit_go)
				ovalid_q <= 1'b1;
			else if (!out_stall)
				ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop)
			it_q <= q.item;
		if (state_q == S_FIND) begin
			outc_q     <= fnd_outc;
			slot_q     <= fnd_slot;
			cli_port_q <= key;
		end
		if (j_ld)
			j_q <= j_d;
		if (open_en) begin
			lport_q[slot_q]  <= (it_q.cmd == CMD_SRV) ? it_q.port_value : cli_port_q;
			lsrv_q[slot_q]   <= (it_q.cmd == CMD_SRV);
			nsid_q[slot_q]   <= (it_q.cmd == CMD_SRV) ? 16'd0 : 16'd1;
			latidx_q[slot_q] <= '0;
		end
		if (add_en) begin
			nsid_q[slot_q]   <= nsid_q[slot_q] + 16'd1;
			latidx_q[slot_q] <= wr_j;
		end
		if (res_ld)
			res_q <= res_d;
		if (emit_go)
			out_q <= res_q;
	end

	// flow memory: one write, one registered read
	always_ff @(posedge clk) begin
		if (mem_we)
			mem[base_addr + AW'(wr_j)] <= mem_wd;
		if (rd_en)
			rd_q <= mem[base_addr + AW'(rd_j)];
	end

	assign res       = out_q;
	assign out_valid = ovalid_q;

	`UDPFD_ASSERT(a_scan_range, (state_q != S_SCAN) || (j_q < n_cur), "flow scan past count")
	`UDPFD_ASSERT_NEXT(a_emit_load, (state_q == S_EMIT) && (!ovalid_q || !out_stall), ovalid_q && (state_q == S_IDLE), "result not loaded")
	`UDPFD_ASSERT_NEXT(a_open_valid, open_en, lv_q[slot_q], "opened slot not marked valid")

endmodule

// File: tb/udp_port_flow_demux_table_checker.sv
`timescale 1ns / 1ps
module udp_port_flow_demux_table_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [2:0]  cmd,
	input  logic [31:0] peer_address,
	input  logic [15:0] src_port,
	input  logic [15:0] port_value,
	input  logic [2:0]  slot_select,
	input  logic [15:0] socket_select,
	input  logic [15:0] payload_length,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [2:0]  status,
	input  logic [2:0]  slot_out,
	input  logic        is_server,
	input  logic [15:0] socket_out,
	input  logic [31:0] remote_address_out,
	input  logic [15:0] remote_port_out,
	input  logic [15:0] local_port_out,
	input  logic [31:0] source_address_out,
	input  logic [15:0] udp_length_out,
	output int          fail_count,
	output int          pending
);
	import udpfd_pkg::*;

	localparam int NSLOT = 8;
	localparam int NFLOW = 16;

	logic [31:0] own_ip;
	logic [15:0] eph_base;
	logic [15:0] eph_off;
	logic        slot_open [NSLOT];
	logic [15:0] slot_port [NSLOT];
	logic        slot_srv  [NSLOT];
	logic [15:0] slot_next_sock [NSLOT];
	int          slot_flows [NSLOT];
	logic [31:0] fl_addr [NSLOT][NFLOW];
	logic [15:0] fl_port [NSLOT][NFLOW];
	logic [15:0] fl_sock [NSLOT][NFLOW];

	result_t expected_results [$];

	assign pending = expected_results.size();

	function automatic result_t mk(status_t st, int s, logic srv, logic [15:0] sk,
			logic [31:0] ra, logic [15:0] rp, logic [15:0] lp);
		result_t r;
		r = '0;
		r.status = st;
		r.slot_out = s[2:0];
		r.is_server = srv;
		r.socket_out = sk;
		r.remote_address_out = ra;
		r.remote_port_out = rp;
		r.local_port_out = lp;
		return r;
	endfunction

	function automatic int port_slot(logic [15:0] p);
		for (int i = 0; i < NSLOT; i++)
			if (slot_open[i] && slot_port[i] == p) return i;
		return -1;
	endfunction

	function automatic int free_slot();
		for (int i = 0; i < NSLOT; i++)
			if (!slot_open[i]) return i;
		return -1;
	endfunction

	function automatic void claim(int s, logic [15:0] p, logic srv);
		slot_open[s] = 1'b1;
		slot_port[s] = p;
		slot_srv[s] = srv;
		slot_next_sock[s] = '0;
		slot_flows[s] = 0;
	endfunction

	function automatic logic [15:0] learn(int s, logic [31:0] a, logic [15:0] p);
		int n;
		n = slot_flows[s];
		fl_addr[s][n] = a;
		fl_port[s][n] = p;
		fl_sock[s][n] = slot_next_sock[s];
		slot_next_sock[s] = slot_next_sock[s] + 16'd1;
		slot_flows[s] = n + 1;
		return fl_sock[s][n];
	endfunction

	// one expectation per valid command; unknown commands are dropped
	function automatic void route_item(item_t it);
		int s, h;
		logic [15:0] lp, sk;
		result_t r;
		case (it.cmd)
			CMD_DGRAM: begin
				s = port_slot(it.port_value);
				if (s < 0) begin
					expected_results.push_back(mk(ST_NOPORT, 0, 0, 0, 0, 0, 0));
					return;
				end
				for (int j = 0; j < slot_flows[s]; j++)
					if (fl_addr[s][j] == it.peer_address && fl_port[s][j] == it.src_port) begin
						expected_results.push_back(mk(ST_OK, s, slot_srv[s], fl_sock[s][j],
							it.peer_address, it.src_port, slot_port[s]));
						return;
					end
				if (!slot_srv[s])
					expected_results.push_back(mk(ST_UNKPEER, s, 0, 0, it.peer_address,
						it.src_port, slot_port[s]));
				else if (slot_flows[s] >= NFLOW)
					expected_results.push_back(mk(ST_FULL, s, 1, 0, it.peer_address,
						it.src_port, slot_port[s]));
				else begin
					sk = learn(s, it.peer_address, it.src_port);
					expected_results.push_back(mk(ST_NEW, s, 1, sk, it.peer_address,
						it.src_port, slot_port[s]));
				end
			end
			CMD_SRV: begin
				s = port_slot(it.port_value);
				if (s >= 0) begin
					expected_results.push_back(mk(ST_INUSE, s, slot_srv[s], 0, 0, 0,
						it.port_value));
					return;
				end
				s = free_slot();
				if (s < 0) begin
					expected_results.push_back(mk(ST_FULL, 0, 0, 0, 0, 0, 0));
					return;
				end
				claim(s, it.port_value, 1'b1);
				expected_results.push_back(mk(ST_OK, s, 1, 0, 0, 0, it.port_value));
			end
			CMD_CLI: begin
				s = free_slot();
				if (s < 0) begin
					expected_results.push_back(mk(ST_FULL, 0, 0, 0, 0, 0, 0));
					return;
				end
				lp = eph_base + eph_off;
				eph_off = eph_off + 16'd1;
				h = port_slot(lp);
				if (h >= 0) begin
					expected_results.push_back(mk(ST_INUSE, h, slot_srv[h], 0, 0, 0, lp));
					return;
				end
				claim(s, lp, 1'b0);
				sk = learn(s, it.peer_address, it.port_value);
				expected_results.push_back(mk(ST_OK, s, 0, 0, it.peer_address,
					it.port_value, lp));
			end
			CMD_SEND, CMD_LATEST: begin
				s = it.slot_select;
				if (!slot_open[s]) begin
					expected_results.push_back(mk(ST_EMPTY, s, 0, 0, 0, 0, 0));
					return;
				end
				if (it.cmd == CMD_LATEST) begin
					h = slot_flows[s] - 1;
					if (h < 0)
						expected_results.push_back(mk(ST_EMPTY, s, slot_srv[s], 0, 0, 0,
							slot_port[s]));
					else
						expected_results.push_back(mk(ST_OK, s, slot_srv[s], fl_sock[s][h],
							fl_addr[s][h], fl_port[s][h], slot_port[s]));
					return;
				end
				for (int j = 0; j < slot_flows[s]; j++)
					if (fl_sock[s][j] == it.socket_select) begin
						r = mk(ST_OK, s, slot_srv[s], it.socket_select, fl_addr[s][j],
							fl_port[s][j], slot_port[s]);
						r.source_address_out = own_ip;
						r.udp_length_out = it.payload_length + UDP_HDR_BYTES;
						expected_results.push_back(r);
						return;
					end
				expected_results.push_back(mk(ST_UNKSOCK, s, slot_srv[s], 0, 0, 0,
					slot_port[s]));
			end
			default: ;
		endcase
	endfunction

	item_t   seen_item;
	result_t seen_res, want;

	always_comb begin
		seen_item = {cmd, peer_address, src_port, port_value, slot_select,
			socket_select, payload_length};
		seen_res = {status, slot_out, is_server, socket_out, remote_address_out,
			remote_port_out, local_port_out, source_address_out, udp_length_out};
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_ip <= '0;
			eph_base <= PORT_BASE_RESET;
			eph_off = '0;
			fail_count <= 0;
			for (int i = 0; i < NSLOT; i++) begin
				slot_open[i] = 1'b0;
				slot_flows[i] = 0;
			end
			expected_results.delete();
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_LOCAL_IP) own_ip <= cfg_data;
				else eph_base <= cfg_data[15:0];
			end
			// result checked before the same-edge item is predicted
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected result %p", seen_res);
					fail_count <= fail_count + 1;
				end else begin
					want = expected_results.pop_front();
					if (want !== seen_res) begin
						if (fail_count < 10)
							$display("mismatch: expected %p got %p", want, seen_res);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (in_valid && !in_stall) route_item(seen_item);
		end
	end

endmodule

// File: tb/udp_port_flow_demux_table_core_tb.sv
`timescale 1ns / 1ps
module udp_port_flow_demux_table_core_tb;
	import udpfd_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [0:0]  cfg_index;
	logic [31:0] cfg_data;
	logic        in_valid, in_stall, out_valid, out_stall;
	logic [2:0]  cmd, slot_select, status, slot_out;
	logic [31:0] peer_address, remote_address_out, source_address_out;
	logic [15:0] src_port, port_value, socket_select, payload_length;
	logic [15:0] socket_out, remote_port_out, local_port_out, udp_length_out;
	logic        is_server;
	int          fail_count, pending;

	// receiver hold-off request from the stimulus process
	logic        hold_off;
	int          idle_cycles;

	udp_port_flow_demux_table_core dut (.*);
	udp_port_flow_demux_table_checker chk (.*);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// small pools so datagrams hit open ports and known peers often
	logic [15:0] port_pool [4] = '{16'd7, 16'd53, 16'hFFFF, 16'd0};
	logic [31:0] addr_pool [4] = '{32'h0A000001, 32'hFFFFFFFF, 32'h0, 32'hC0A80102};

	function automatic int short_gap();
		if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
		if ($urandom_range(0, 2) == 0) return 0;
		return $urandom_range(0, 3);
	endfunction

	// receiver: random stalls, plus one long hold-off once asked
	initial begin
		int n;
		bit held;
		held = 1'b0;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_off && !held) begin
				held = 1'b1;
				out_stall <= 1'b1;
				repeat (300) @(posedge clk);
				out_stall <= 1'b0;
				@(posedge clk);
			end else begin
				n = short_gap();
				out_stall <= (n != 0);
				repeat (n == 0 ? $urandom_range(1, 8) : n) @(posedge clk);
			end
		end
	end

	// one item through the handshake, then a random gap when gaps is set
	task automatic send_item(logic [2:0] c, logic [31:0] pa, logic [15:0] sp,
			logic [15:0] pv, logic [2:0] ss, logic [15:0] sk, logic [15:0] pl, bit gaps);
		int g;
		in_valid <= 1'b1;
		cmd <= c; peer_address <= pa; src_port <= sp; port_value <= pv;
		slot_select <= ss; socket_select <= sk; payload_length <= pl;
		do @(posedge clk); while (in_stall);
		g = gaps ? short_gap() : 0;
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	task automatic end_phase();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		// opens and learns are done before their result, so the engine is already idle here
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(logic [0:0] idx, logic [31:0] v);
		cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic random_item(int mode);
		logic [2:0] c;
		int r;
		r = $urandom_range(0, 99);
		if (mode == 0)
			c = r < 55 ? CMD_DGRAM : r < 62 ? CMD_SRV : r < 69 ? CMD_CLI :
				r < 84 ? CMD_SEND : r < 97 ? CMD_LATEST : 3'($urandom_range(5, 7));
		else
			c = 3'($urandom_range(0, 7));
		send_item(c,
			r[0] ? addr_pool[$urandom_range(0, 3)] : $urandom,
			$urandom_range(0, 3) != 0 ? 16'($urandom_range(0, 20)) : 16'($urandom),
			$urandom_range(0, 4) != 0 ? port_pool[$urandom_range(0, 3)] : 16'($urandom),
			3'($urandom_range(0, 7)),
			$urandom_range(0, 4) != 0 ? 16'($urandom_range(0, 17)) : 16'($urandom),
			16'($urandom), 1'b1);
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
		in_valid = 1'b0; cmd = '0; peer_address = '0; src_port = '0;
		port_value = '0; slot_select = '0; socket_select = '0; payload_length = '0;
		hold_off = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty table, opens, learning, refusals, lookups, edge lengths
		send_item(CMD_DGRAM, 32'h1, 16'd1, 16'd7, 3'd0, 16'd0, 16'd0, 1'b0);
		send_item(CMD_LATEST, 32'h0, 16'd0, 16'd0, 3'd7, 16'd0, 16'd0, 1'b0);
		send_item(CMD_SRV, 32'h0, 16'd0, 16'd7, 3'd0, 16'd0, 16'd0, 1'b0);
		send_item(CMD_SRV, 32'h0, 16'd0, 16'd7, 3'd0, 16'd0, 16'd0, 1'b0);
		send_item(CMD_LATEST, 32'h0, 16'd0, 16'd0, 3'd0, 16'd0, 16'd0, 1'b0);
		send_item(CMD_DGRAM, 32'hFFFFFFFF, 16'hFFFF, 16'd7, 3'd0, 16'd0, 16'd0, 1'b0);
		send_item(CMD_DGRAM, 32'hFFFFFFFF, 16'hFFFF, 16'd7, 3'd0, 16'd0, 16'd0, 1'b0);
		send_item(CMD_SEND, 32'h0, 16'd0, 16'd0, 3'd0, 16'd0, 16'hFFFF, 1'b0);
		send_item(CMD_SEND, 32'h0, 16'd0, 16'd0, 3'd0, 16'd9, 16'd0, 1'b0);
		send_item(CMD_CLI, 32'h12345678, 16'd0, 16'd80, 3'd0, 16'd0, 16'd0, 1'b0);
		send_item(CMD_DGRAM, 32'h1, 16'd2, 16'd50000, 3'd0, 16'd0, 16'd0, 1'b0);
		send_item(CMD_SEND, 32'h0, 16'd0, 16'd0, 3'd1, 16'd0, 16'd65527, 1'b0);
		send_item(CMD_SRV, 32'h0, 16'd0, 16'd50001, 3'd0, 16'd0, 16'd0, 1'b0);
		send_item(CMD_CLI, 32'h1, 16'd0, 16'd1, 3'd0, 16'd0, 16'd0, 1'b0);
		send_item(3'd5, 32'h0, 16'd0, 16'd7, 3'd0, 16'd0, 16'd0, 1'b0);
		send_item(3'd7, 32'h0, 16'd0, 16'd7, 3'd0, 16'd0, 16'd0, 1'b0);
		// fill the server on port 7 past its flow capacity
		for (int i = 0; i < 16; i++)
			send_item(CMD_DGRAM, 32'hA0 + i, 16'd5, 16'd7, 3'd0, 16'd0, 16'd0, 1'b0);
		// fill the slots and try once more
		for (int i = 0; i < 7; i++)
			send_item(CMD_SRV, 32'h0, 16'd0, 16'd1000 + i, 3'd0, 16'd0, 16'd0, 1'b0);
		send_item(CMD_CLI, 32'h0, 16'd0, 16'd0, 3'd0, 16'd0, 16'd0, 1'b0);
		end_phase();

		// phases over register settings, extremes included; reset is never reapplied,
		// so the table stays full and ports stay taken
		for (int ph = 0; ph < 4; ph++) begin
			write_reg(CFG_LOCAL_IP, ph == 0 ? 32'hFFFFFFFF : ph == 1 ? 32'h0 : $urandom);
			write_reg(CFG_PORT_BASE, ph == 0 ? 32'hFFFF : ph == 1 ? 32'h0 :
				32'($urandom_range(0, 65535)));
			if (ph == 2) hold_off <= 1'b1;
			for (int i = 0; i < 160; i++)
				random_item(i % 10 == 9);
			end_phase();
		end

		if (fail_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// watchdog on cycles without any handshake
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 5000) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial idle_cycles = 0;

endmodule

// File: sim.f
+incdir+rtl
rtl/udpfd_pkg.sv
rtl/udpfd_front.sv
rtl/udpfd_engine.sv
rtl/udp_port_flow_demux_table_core.sv
tb/udp_port_flow_demux_table_checker.sv
tb/udp_port_flow_demux_table_core_tb.sv
